### rtl/fppc_pkg.sv
`default_nettype none
package fppc_pkg;
  localparam int MaxPointsDef = 64;
  localparam int CoordBitsDef = 16;
  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAdd = 2'd1;
  localparam logic [1:0] ModeClassify = 2'd2;
  localparam logic [15:0] PrecisionReset = 16'd1;
endpackage
`default_nettype wire

### rtl/fppc_ram.sv
`default_nettype none
module fppc_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/face_plane_point_classifier.sv
// Clear, mode 3 and a classify with fewer than three points go straight to the result; add
// checks for a duplicate with one store read per stored point, then stores a new point if the
// store has room; classify uses a cached plane at once, else searches for the first point off
// the line of points 0 and 1 and builds the plane from it, or gives side 0 when none exists.
// Throughput: one item in flight; the next item is taken the cycle after a result is loaded.
// Reset (rst_n synchronous, low): store empty, no plane, precision 1. No clearing pass.
`default_nettype none
module face_plane_point_classifier #(
  parameter int MAX_POINTS = fppc_pkg::MaxPointsDef,
  parameter int COORD_BITS = fppc_pkg::CoordBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[1:0], point_x[17:2], point_y[33:18], point_z[49:34]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // side[1:0], stored[2], duplicate[3], store_full[4], plane_found[5], count_now[12:6]
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import fppc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 3 * COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int KW = 2 * DW + 1;
  localparam int MW = KW + COORD_BITS + 2;
  localparam int EW = 64;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DUP   = 10'b0000000010,
    S_BASE0 = 10'b0000000100,
    S_BASE1 = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DOFF  = 10'b0001000000,
    S_NORM  = 10'b0010000000,
    S_EVAL  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] mode_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [15:0] prec_r;
  logic [CW-1:0] cnt_r;
  logic plane_r;
  logic signed [EW-1:0] ca_r, cb_r, cc_r, cd_r;
  logic [CW-1:0] k_r;
  logic rd_pend_r;
  logic dup_r;
  logic signed [COORD_BITS-1:0] x0_r, y0_r, z0_r;
  logic signed [DW-1:0] ux_r, uy_r, uz_r;
  logic signed [EW-1:0] t_r;
  logic signed [EW-1:0] m1_r, m2_r, m3_r;
  logic [EW-1:0] mm_r;
  logic st_r, full_r;
  logic [AW-1:0] raddr;
  logic [PW-1:0] rdata;
  logic we;
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic signed [DW-1:0] vx, vy, vz;
  logic signed [2*DW-1:0] q1, q2, q3, q4, q5, q6;
  logic signed [KW-1:0] na, nb, nc;
  logic [EW-1:0] mga, mgb, mgc, mgd, mm;
  logic signed [EW-1:0] mval;
  logic [MW+16-1:0] tprod;
  logic signed [KW-1:0] mula, mulb, mulc;
  logic signed [COORD_BITS-1:0] mx, my, mz;
  logic signed [KW+COORD_BITS-1:0] pa, pb, pc;
  logic signed [EW-1:0] eval;
  logic [1:0] side_val;
  logic out_load;

  fppc_ram #(.Width(PW), .Depth(MAX_POINTS)) u_store (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata({pz_r, py_r, px_r}),
    .raddr(raddr), .rdata(rdata)
  );

  assign rx = rdata[COORD_BITS-1:0];
  assign ry = rdata[2*COORD_BITS-1:COORD_BITS];
  assign rz = rdata[PW-1:2*COORD_BITS];
  assign vx = DW'(rx) - DW'(x0_r);
  assign vy = DW'(ry) - DW'(y0_r);
  assign vz = DW'(rz) - DW'(z0_r);
  assign q1 = uy_r * vz;
  assign q2 = uz_r * vy;
  assign q3 = uz_r * vx;
  assign q4 = ux_r * vz;
  assign q5 = ux_r * vy;
  assign q6 = uy_r * vx;
  assign na = KW'(q1) - KW'(q2);
  assign nb = KW'(q3) - KW'(q4);
  assign nc = KW'(q5) - KW'(q6);
  assign raddr = k_r[AW-1:0];
  assign we = (state_r == S_DUP) && !rd_pend_r && (k_r >= cnt_r) && !dup_r
              && (cnt_r < CW'(MAX_POINTS));

  assign mula = ca_r[KW-1:0];
  assign mulb = cb_r[KW-1:0];
  assign mulc = cc_r[KW-1:0];
  assign mx = (state_r == S_MUL) ? x0_r : px_r;
  assign my = (state_r == S_MUL) ? y0_r : py_r;
  assign mz = (state_r == S_MUL) ? z0_r : pz_r;
  assign pa = mula * mx;
  assign pb = mulb * my;
  assign pc = mulc * mz;

  assign mga = ca_r[EW-1] ? EW'(-ca_r) : EW'(ca_r);
  assign mgb = cb_r[EW-1] ? EW'(-cb_r) : EW'(cb_r);
  assign mgc = cc_r[EW-1] ? EW'(-cc_r) : EW'(cc_r);
  assign mgd = cd_r[EW-1] ? EW'(-cd_r) : EW'(cd_r);
  always_comb begin
    mm = mga; mval = ca_r;
    if (mgb > mm) begin mm = mgb; mval = cb_r; end
    if (mgc > mm) begin mm = mgc; mval = cc_r; end
    if (mgd > mm) begin mm = mgd; mval = cd_r; end
  end
  assign tprod = (MW+16)'(prec_r) * (MW+16)'(mm_r[MW-1:0]);

  assign eval = m1_r + m2_r + m3_r + cd_r;

  always_comb begin
    side_val = 2'b00;
    if (mode_r == ModeClassify && plane_r) begin
      if (eval > t_r) side_val = 2'b01;
      else if (eval < -t_r) side_val = 2'b11;
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_tvalid || out_tready);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid && in_tready) begin
        if (in_tdata[1:0] == ModeAdd) state_nxt = S_DUP;
        else if (in_tdata[1:0] == ModeClassify)
          state_nxt = plane_r ? S_EVAL : (cnt_r < CW'(3) ? S_OUT : S_BASE0);
        else state_nxt = S_OUT;
      end
      S_DUP:   if (!rd_pend_r && k_r >= cnt_r) state_nxt = S_OUT;
      S_BASE0: state_nxt = S_BASE1;
      S_BASE1: state_nxt = S_SRCH;
      S_SRCH:  if (rd_pend_r) begin
        if (na != 0 || nb != 0 || nc != 0) state_nxt = S_MUL;
        else if (k_r >= cnt_r) state_nxt = S_OUT;
      end
      S_MUL:   state_nxt = S_DOFF;
      S_DOFF:  state_nxt = S_NORM;
      S_NORM:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prec_r <= PrecisionReset;
      cnt_r <= '0;
      plane_r <= 1'b0;
      out_tvalid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) prec_r <= cfg_wdata;
      if (out_load) begin
        out_tvalid <= 1'b1;
        out_tdata <= {3'b000, 7'(cnt_r), plane_r, full_r, dup_r, st_r, side_val};
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          mode_r <= in_tdata[1:0];
          px_r <= in_tdata[2 +: COORD_BITS];
          py_r <= in_tdata[18 +: COORD_BITS];
          pz_r <= in_tdata[34 +: COORD_BITS];
          k_r <= '0;
          rd_pend_r <= 1'b0;
          dup_r <= 1'b0;
          st_r <= 1'b0;
          full_r <= 1'b0;
          if (in_tdata[1:0] == ModeClear) begin
            cnt_r <= '0;
            plane_r <= 1'b0;
            ca_r <= '0; cb_r <= '0; cc_r <= '0; cd_r <= '0;
          end
        end
        S_DUP: begin
          if (rd_pend_r && rx == px_r && ry == py_r && rz == pz_r) dup_r <= 1'b1;
          if (k_r < cnt_r) begin
            k_r <= k_r + CW'(1);
            rd_pend_r <= 1'b1;
          end else if (!rd_pend_r) begin
            if (!dup_r) begin
              if (cnt_r < CW'(MAX_POINTS)) begin
                cnt_r <= cnt_r + CW'(1);
                st_r <= 1'b1;
              end else full_r <= 1'b1;
            end
          end else rd_pend_r <= 1'b0;
        end
        S_BASE0: k_r <= CW'(1);
        S_BASE1: begin
          x0_r <= rx; y0_r <= ry; z0_r <= rz;
          k_r <= CW'(2);
          rd_pend_r <= 1'b0;
        end
        S_SRCH: begin
          if (!rd_pend_r) begin
            ux_r <= vx; uy_r <= vy; uz_r <= vz;
            rd_pend_r <= 1'b1;
            k_r <= k_r + CW'(1);
          end else if (na != 0 || nb != 0 || nc != 0) begin
            ca_r <= EW'(na); cb_r <= EW'(nb); cc_r <= EW'(nc);
          end else if (k_r < cnt_r) begin
            k_r <= k_r + CW'(1);
          end
        end
        S_MUL: begin
          m1_r <= EW'(pa);
          m2_r <= EW'(pb);
          m3_r <= EW'(pc);
        end
        S_DOFF: cd_r <= -(m1_r + m2_r + m3_r);
        S_NORM: begin
          plane_r <= 1'b1;
          mm_r <= mm;
          if (mval[EW-1]) begin
            ca_r <= -ca_r; cb_r <= -cb_r; cc_r <= -cc_r; cd_r <= -cd_r;
          end
        end
        S_EVAL: begin
          m1_r <= EW'(pa);
          m2_r <= EW'(pb);
          m3_r <= EW'(pc);
          t_r <= EW'(tprod >> 16);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### dv/face_plane_point_classifier_tb.sv
`default_nettype none
module face_plane_point_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fppc_pkg::*;

  localparam int NumPoints = MaxPointsDef;
  localparam int RunItems = 450;
  localparam int CycleLimit = 1000000;
  localparam logic [1:0] ModeIdle = 2'd3;

  typedef struct packed {
    logic [6:0]        count_now;
    logic              plane_found;
    logic              store_full;
    logic              duplicate;
    logic              stored;
    logic signed [1:0] side;
  } face_result_t;

  class face_scoreboard;
    logic [15:0]        precision;
    logic signed [15:0] px[NumPoints];
    logic signed [15:0] py[NumPoints];
    logic signed [15:0] pz[NumPoints];
    int                 count;
    bit                 cached;
    longint             ka, kb, kc, kd;
    face_result_t       due[$];
    int                 errors;
    int                 seen;

    function new();
      precision = PrecisionReset;
      count = 0;
      cached = 0;
      ka = 0; kb = 0; kc = 0; kd = 0;
      errors = 0;
      seen = 0;
    endfunction

    function longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function bit find_plane();
      longint ux, uy, uz, vx, vy, vz, a, b, c, d, m;
      if (count < 3) return 0;
      ux = longint'(px[1]) - px[0];
      uy = longint'(py[1]) - py[0];
      uz = longint'(pz[1]) - pz[0];
      for (int k = 2; k < count; k++) begin
        vx = longint'(px[k]) - px[0];
        vy = longint'(py[k]) - py[0];
        vz = longint'(pz[k]) - pz[0];
        a = uy * vz - uz * vy;
        b = uz * vx - ux * vz;
        c = ux * vy - uy * vx;
        if (a == 0 && b == 0 && c == 0) continue;
        d = -(a * px[0] + b * py[0] + c * pz[0]);
        m = a;
        if (absval(b) > absval(m)) m = b;
        if (absval(c) > absval(m)) m = c;
        if (absval(d) > absval(m)) m = d;
        if (m < 0) begin
          a = -a; b = -b; c = -c; d = -d;
        end
        ka = a; kb = b; kc = c; kd = d;
        return 1;
      end
      return 0;
    endfunction

    function logic signed [1:0] side_of(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z);
      longint e, t;
      longint unsigned mm, p;
      if (!cached) begin
        if (!find_plane()) return 0;
        cached = 1;
      end
      e = ka * x + kb * y + kc * z + kd;
      mm = absval(ka);
      if (absval(kb) > mm) mm = absval(kb);
      if (absval(kc) > mm) mm = absval(kc);
      if (absval(kd) > mm) mm = absval(kd);
      p = precision;
      t = p * (mm >> 16) + ((p * (mm & 64'hFFFF)) >> 16);
      if (e > t) return 1;
      if (e < -t) return -1;
      return 0;
    endfunction

    function void note_item(logic [1:0] mode, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      face_result_t r;
      r = '0;
      case (mode)
        ModeClear: begin
          count = 0;
          cached = 0;
          ka = 0; kb = 0; kc = 0; kd = 0;
        end
        ModeAdd: begin
          for (int k = 0; k < count; k++)
            if (px[k] == x && py[k] == y && pz[k] == z) r.duplicate = 1;
          if (!r.duplicate) begin
            if (count >= NumPoints) begin
              r.store_full = 1;
            end else begin
              px[count] = x; py[count] = y; pz[count] = z;
              count++;
              r.stored = 1;
            end
          end
        end
        ModeClassify: r.side = side_of(x, y, z);
        default: ;
      endcase
      r.plane_found = cached;
      r.count_now = count[6:0];
      due = {due, r};
    endfunction

    function void check_result(logic [15:0] data);
      face_result_t got, want;
      got = data[12:0];
      seen++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d: no item outstanding, got %h", seen, got);
        return;
      end
      want = due.pop_front();
      if (got.side !== want.side || got.stored !== want.stored ||
          got.duplicate !== want.duplicate || got.store_full !== want.store_full ||
          got.plane_found !== want.plane_found || got.count_now !== want.count_now) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d: exp side=%0d st=%b dup=%b full=%b pl=%b cnt=%0d",
                   seen, want.side, want.stored, want.duplicate, want.store_full,
                   want.plane_found, want.count_now);
          $display("result %0d: got side=%0d st=%b dup=%b full=%b pl=%b cnt=%0d",
                   seen, got.side, got.stored, got.duplicate,
                   got.store_full, got.plane_found, got.count_now);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  face_scoreboard sb = new();
  bit  calm;
  bit  hold_req;
  int  sent;
  longint cycles;

  face_plane_point_classifier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (500) @(posedge clk);
        hold_req = 0;
        out_tready <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 70) begin
          out_tready <= 1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
          out_tready <= 0;
        end
      end
    end
  end

  function automatic logic [15:0] pick_coord(bit wide);
    return wide ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = (calm || r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, z, y, x, mode};
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, x, y, z);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_precision(logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.precision = v;
  endtask

  initial begin
    int n, k, r;
    bit wide;
    cycles = 0;
    sent = 0;
    calm = 0;
    hold_req = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    cfg_we <= 0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(ModeClear, 0, 0, 0);
    send_item(ModeClassify, 0, 0, 0);
    send_item(ModeAdd, 0, 0, 0);
    send_item(ModeAdd, 0, 0, 0);
    send_item(ModeAdd, 1, 1, 1);
    send_item(ModeAdd, 2, 2, 2);
    send_item(ModeClassify, 5, -3, 2);
    send_item(ModeAdd, 16'sd32767, -16'sd32768, 0);
    send_item(ModeClassify, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(ModeClassify, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(ModeClassify, 0, 0, 0);
    send_item(ModeIdle, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ModeAdd, 1, 0, 0);
    send_item(ModeClassify, 1, 1, 1);
    drain();
    write_precision(16'd0);
    send_item(ModeClassify, 3, -7, 1);
    send_item(ModeClassify, 2, 2, 2);
    drain();
    write_precision(16'hFFFF);
    send_item(ModeClassify, 3, -7, 1);
    send_item(ModeClassify, -16'sd32768, 16'sd32767, -16'sd32768);
    drain();

    for (int phase = 0; sent < RunItems; phase++) begin
      drain();
      r = $urandom_range(0, 9);
      if (r < 2) write_precision(r == 0 ? 16'd0 : 16'hFFFF);
      else if (r < 6) write_precision(16'($urandom_range(0, 3000)));
      else if (r < 7) write_precision(16'($urandom));
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 1 || $urandom_range(0, 15) == 0) hold_req = 1;
      wide = ($urandom_range(0, 3) == 0);
      send_item(ModeClear, pick_coord(1), pick_coord(1), pick_coord(1));
      n = (phase == 2 || $urandom_range(0, 19) == 0) ? $urandom_range(64, 70)
                                                     : $urandom_range(0, 8);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0 && sb.count > 0) begin
          int j;
          j = $urandom_range(0, sb.count - 1);
          send_item(ModeAdd, sb.px[j], sb.py[j], sb.pz[j]);
        end else if (r == 1 && n < 10) begin
          send_item(ModeClassify, pick_coord(wide), pick_coord(wide), pick_coord(wide));
        end else begin
          send_item(ModeAdd, pick_coord(wide), pick_coord(wide), pick_coord(wide));
        end
      end
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        if (r < 2 && sb.count > 0) begin
          int j;
          j = $urandom_range(0, sb.count - 1);
          send_item(ModeClassify, sb.px[j], sb.py[j], sb.pz[j]);
        end else if (r == 2) begin
          send_item(2'($urandom), pick_coord(1), pick_coord(1), pick_coord(1));
        end else if (r == 3) begin
          send_item(ModeAdd, pick_coord(wide), pick_coord(wide), pick_coord(wide));
        end else begin
          send_item(ModeClassify, pick_coord(wide), pick_coord(wide), pick_coord(wide));
        end
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
